// ----- hdl/ptd_pkg.sv -----
package ptd_pkg;

   // result kinds carried on rsp_tuser
   localparam logic [1:0] KIND_STATUS = 2'd0;
   localparam logic [1:0] KIND_DUE    = 2'd1;
   localparam logic [1:0] KIND_NONE   = 2'd2;

   // request op carried on req_tuser
   localparam logic OP_REGISTER = 1'b0;
   localparam logic OP_TICK     = 1'b1;

   // microprogram addresses
   typedef enum logic [2:0] {
      STEP_IDLE      = 3'd0,
      STEP_DISPATCH  = 3'd1,
      STEP_REG_SCAN  = 3'd2,
      STEP_REG_DONE  = 3'd3,
      STEP_TICK_SCAN = 3'd4,
      STEP_TICK_DONE = 3'd5
   } ptd_step_type;

   // jump conditions
   typedef enum logic [1:0] {
      JC_ALWAYS = 2'd0,
      JC_NO_REQ = 2'd1,
      JC_TICK   = 2'd2,
      JC_END    = 2'd3
   } ptd_cond_type;

   // per-entry work done while walking the table
   typedef enum logic [1:0] {
      WALK_NONE = 2'd0,
      WALK_DUP  = 2'd1,
      WALK_DUE  = 2'd2
   } ptd_walk_type;

   // result source
   typedef enum logic [1:0] {
      EM_NONE   = 2'd0,
      EM_STATUS = 2'd1,
      EM_DUE    = 2'd2,
      EM_FINAL  = 2'd3
   } ptd_emit_type;

   typedef struct packed {
      ptd_cond_type cond;
      ptd_step_type target;
      logic         hold;     // stay on this step when the condition is false
      logic         load;     // take a request beat
      ptd_walk_type walk;
      logic         commit;   // append the new entry if registration is good
      ptd_emit_type emit;
   } ptd_ctl_type;

   function automatic ptd_ctl_type ptd_rom(ptd_step_type step);
      ptd_ctl_type w;
      w = '{cond: JC_ALWAYS, target: STEP_IDLE, hold: 1'b0, load: 1'b0,
            walk: WALK_NONE, commit: 1'b0, emit: EM_NONE};
      unique case (step)
         STEP_IDLE: begin
            w.cond   = JC_NO_REQ;
            w.target = STEP_IDLE;
            w.load   = 1'b1;
         end
         STEP_DISPATCH: begin
            w.cond   = JC_TICK;
            w.target = STEP_TICK_SCAN;
         end
         STEP_REG_SCAN: begin
            w.cond   = JC_END;
            w.target = STEP_REG_DONE;
            w.hold   = 1'b1;
            w.walk   = WALK_DUP;
         end
         STEP_REG_DONE: begin
            w.commit = 1'b1;
            w.emit   = EM_STATUS;
         end
         STEP_TICK_SCAN: begin
            w.cond   = JC_END;
            w.target = STEP_TICK_DONE;
            w.hold   = 1'b1;
            w.walk   = WALK_DUE;
            w.emit   = EM_DUE;
         end
         STEP_TICK_DONE: begin
            w.emit   = EM_FINAL;
         end
         default: begin
            w.target = STEP_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

// ----- hdl/periodic_task_dispatcher_unit.sv -----
// channel  dir  ports                  payload
// req      in   req_tvalid/tready      tuser: op; tdata: task_id, task_present, init_ok,
//                                      period, now_us
// rsp      out  rsp_tvalid/tready      tuser: kind; tdata: reg_error, due_task_id, due_slot;
//                                      tlast: last
//
// a beat of either kind keeps the port closed from accept until the walk ends and its final
// result is registered, longer while the result side stalls; the walk reads one table entry
// a cycle unless a result stalls, through the single registered read port of the task table
// reset clears the step counter, the entry count and the output register; the table
// itself is not cleared, entries at or above the count are never looked at
// a step that produces a result waits while the output register is still full and not taken
module periodic_task_dispatcher_unit #(
   parameter int MAX_TASKS = 16,
   parameter int TIME_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [0:0]  req_tuser,   // op
   input  logic [79:0] req_tdata,   // task_id[7:0], task_present[8], init_ok[9],
                                    // period[41:10], now_us[73:42], zero fill
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [1:0]  rsp_tuser,   // kind
   output logic [15:0] rsp_tdata,   // reg_error[0], due_task_id[8:1], due_slot[12:9],
                                    // zero fill
   output logic        rsp_tlast    // last
);

   localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int CNT_W = $clog2(MAX_TASKS + 1);

   // sequencer
   ptd_pkg::ptd_step_type step_ff, step_in;
   ptd_pkg::ptd_ctl_type  ctl;

   // latched request
   logic                 op_ff, op_in;
   logic [7:0]           id_ff, id_in;
   logic                 present_ff, present_in;
   logic                 init_ok_ff, init_ok_in;
   logic [TIME_BITS-1:0] period_ff, period_in;
   logic [TIME_BITS-1:0] now_ff, now_in;

   // walk state
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic             dup_ff, dup_in;
   logic             pend_valid_ff, pend_valid_in;
   logic [7:0]       pend_id_ff, pend_id_in;
   logic [3:0]       pend_slot_ff, pend_slot_in;

   // output register
   logic       out_valid_ff, out_valid_in;
   logic [1:0] out_kind_ff, out_kind_in;
   logic       out_err_ff, out_err_in;
   logic [7:0] out_id_ff, out_id_in;
   logic [3:0] out_slot_ff, out_slot_in;
   logic       out_last_ff, out_last_in;

   // table ports
   logic [7:0]           rd_task;
   logic [TIME_BITS-1:0] rd_period, rd_last;
   logic                 new_we, run_we;

   logic                 accept, at_end, full, reg_err, due, cond_true;
   logic                 emit_now, stall, walk_go;
   logic [TIME_BITS-1:0] elapsed;
   logic [TIME_BITS+31:0] period_wide, now_wide;
   logic [CNT_W+3:0]     slot_wide;

   // times come in 32 bits wide and are taken modulo 2^TIME_BITS
   assign period_wide = {{TIME_BITS{1'b0}}, req_tdata[41:10]};
   assign now_wide    = {{TIME_BITS{1'b0}}, req_tdata[73:42]};
   assign slot_wide   = {4'b0000, idx_ff};

   assign ctl        = ptd_pkg::ptd_rom(step_ff);
   assign req_tready = ctl.load;
   assign accept     = req_tvalid && req_tready;

   assign at_end  = (idx_ff == count_ff);
   assign full    = (count_ff == CNT_W'(MAX_TASKS));
   assign reg_err = !(present_ff && init_ok_ff) || dup_ff || full;
   assign elapsed = now_ff - rd_last;
   assign due     = (elapsed >= rd_period);

   always_comb begin
      unique case (ctl.cond)
         ptd_pkg::JC_ALWAYS: cond_true = 1'b1;
         ptd_pkg::JC_NO_REQ: cond_true = !accept;
         ptd_pkg::JC_TICK:   cond_true = (op_ff == ptd_pkg::OP_TICK);
         ptd_pkg::JC_END:    cond_true = at_end;
         default:            cond_true = 1'b1;
      endcase

      // a due entry pushes out the one held before it; the held one goes last at the end
      unique case (ctl.emit)
         ptd_pkg::EM_NONE:   emit_now = 1'b0;
         ptd_pkg::EM_STATUS: emit_now = 1'b1;
         ptd_pkg::EM_DUE:    emit_now = !at_end && due && pend_valid_ff;
         ptd_pkg::EM_FINAL:  emit_now = 1'b1;
         default:            emit_now = 1'b0;
      endcase

      stall   = emit_now && out_valid_ff && !rsp_tready;
      walk_go = (ctl.walk != ptd_pkg::WALK_NONE) && !at_end && !stall;

      // next step
      if (stall) begin
         step_in = step_ff;
      end else if (cond_true) begin
         step_in = ctl.target;
      end else if (ctl.hold) begin
         step_in = step_ff;
      end else begin
         step_in = ptd_pkg::ptd_step_type'(step_ff + 3'd1);
      end

      op_in         = op_ff;
      id_in         = id_ff;
      present_in    = present_ff;
      init_ok_in    = init_ok_ff;
      period_in     = period_ff;
      now_in        = now_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      dup_in        = dup_ff;
      pend_valid_in = pend_valid_ff;
      pend_id_in    = pend_id_ff;
      pend_slot_in  = pend_slot_ff;
      new_we        = 1'b0;
      run_we        = 1'b0;

      if (ctl.load && accept) begin
         op_in         = req_tuser[0];
         id_in         = req_tdata[7:0];
         present_in    = req_tdata[8];
         init_ok_in    = req_tdata[9];
         period_in     = period_wide[TIME_BITS-1:0];
         now_in        = now_wide[TIME_BITS-1:0];
         idx_in        = '0;
         dup_in        = 1'b0;
         pend_valid_in = 1'b0;
      end

      if (walk_go) begin
         idx_in = idx_ff + CNT_W'(1);
         if (ctl.walk == ptd_pkg::WALK_DUP) begin
            dup_in = dup_ff || (rd_task == id_ff);
         end else if (due) begin
            run_we        = 1'b1;
            pend_valid_in = 1'b1;
            pend_id_in    = rd_task;
            pend_slot_in  = slot_wide[3:0];
         end
      end

      if (ctl.commit && !stall && !reg_err) begin
         new_we   = 1'b1;
         count_in = count_ff + CNT_W'(1);
      end

      // output register
      out_valid_in = out_valid_ff && !rsp_tready;
      out_kind_in  = out_kind_ff;
      out_err_in   = out_err_ff;
      out_id_in    = out_id_ff;
      out_slot_in  = out_slot_ff;
      out_last_in  = out_last_ff;
      if (emit_now && !stall) begin
         out_valid_in = 1'b1;
         out_err_in   = 1'b0;
         out_id_in    = pend_id_ff;
         out_slot_in  = pend_slot_ff;
         out_last_in  = 1'b1;
         out_kind_in  = ptd_pkg::KIND_DUE;
         unique case (ctl.emit)
            ptd_pkg::EM_STATUS: begin
               out_kind_in = ptd_pkg::KIND_STATUS;
               out_err_in  = reg_err;
               out_id_in   = '0;
               out_slot_in = '0;
            end
            ptd_pkg::EM_DUE: begin
               out_last_in = 1'b0;
            end
            ptd_pkg::EM_FINAL: begin
               if (!pend_valid_ff) begin
                  out_kind_in = ptd_pkg::KIND_NONE;
                  out_id_in   = '0;
                  out_slot_in = '0;
               end
            end
            default: begin
               out_last_in = 1'b1;
            end
         endcase
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff       <= ptd_pkg::STEP_IDLE;
         count_ff      <= '0;
         idx_ff        <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         step_ff       <= step_in;
         count_ff      <= count_in;
         idx_ff        <= idx_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      id_ff        <= id_in;
      present_ff   <= present_in;
      init_ok_ff   <= init_ok_in;
      period_ff    <= period_in;
      now_ff       <= now_in;
      dup_ff       <= dup_in;
      pend_id_ff   <= pend_id_in;
      pend_slot_ff <= pend_slot_in;
      out_kind_ff  <= out_kind_in;
      out_err_ff   <= out_err_in;
      out_id_ff    <= out_id_in;
      out_slot_ff  <= out_slot_in;
      out_last_ff  <= out_last_in;
   end

   // read address follows the next index so data is ready when the walk gets there
   ptd_task_table #(
      .MAX_TASKS(MAX_TASKS),
      .TIME_BITS(TIME_BITS)
   ) u_table (
      .clock     (clock),
      .rd_addr   (idx_in[IDX_W-1:0]),
      .rd_task   (rd_task),
      .rd_period (rd_period),
      .rd_last   (rd_last),
      .new_we    (new_we),
      .new_addr  (count_ff[IDX_W-1:0]),
      .new_task  (id_ff),
      .new_period(period_ff),
      .run_we    (run_we),
      .run_addr  (idx_ff[IDX_W-1:0]),
      .run_time  (now_ff)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tdata  = {3'b000, out_slot_ff, out_id_ff, out_err_ff};
   assign rsp_tlast  = out_last_ff;

   // table never overfills
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_TASKS))
      else $error("entry count beyond table size");

   // a taken request keeps the port closed on the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_tready)
      else $error("request port open right after accept");

   // status and none-due results are always the only one of their beat
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != ptd_pkg::KIND_DUE) |-> rsp_tlast)
      else $error("single result without last");

   // the walk index never passes the entry count
   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      (step_ff == ptd_pkg::STEP_REG_SCAN || step_ff == ptd_pkg::STEP_TICK_SCAN)
      |-> idx_ff <= count_ff)
      else $error("walk index past entry count");

endmodule

// ----- hdl/ptd_task_table.sv -----
module ptd_task_table #(
   parameter int MAX_TASKS = 16,
   parameter int TIME_BITS = 32,
   localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1
) (
   input  logic                 clock,
   input  logic [IDX_W-1:0]     rd_addr,
   output logic [7:0]           rd_task,
   output logic [TIME_BITS-1:0] rd_period,
   output logic [TIME_BITS-1:0] rd_last,
   input  logic                 new_we,
   input  logic [IDX_W-1:0]     new_addr,
   input  logic [7:0]           new_task,
   input  logic [TIME_BITS-1:0] new_period,
   input  logic                 run_we,
   input  logic [IDX_W-1:0]     run_addr,
   input  logic [TIME_BITS-1:0] run_time
);

   logic [7:0]           task_mem   [MAX_TASKS];
   logic [TIME_BITS-1:0] period_mem [MAX_TASKS];
   logic [TIME_BITS-1:0] last_mem   [MAX_TASKS];

   always_ff @(posedge clock) begin
      if (new_we) begin
         task_mem[new_addr]   <= new_task;
         period_mem[new_addr] <= new_period;
      end
   end

   // a fresh entry starts with last run at zero
   always_ff @(posedge clock) begin
      if (new_we) begin
         last_mem[new_addr] <= '0;
      end else if (run_we) begin
         last_mem[run_addr] <= run_time;
      end
   end

   always_ff @(posedge clock) begin
      rd_task   <= task_mem[rd_addr];
      rd_period <= period_mem[rd_addr];
      rd_last   <= last_mem[rd_addr];
   end

endmodule

// ----- verif/periodic_task_dispatcher_unit_test.sv -----
module periodic_task_dispatcher_unit_test;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_SLOTS   = 16;
   localparam int TAIL_CYCLES = 60;    // well past the end of the longest walk
   localparam int HOLD_CYCLES = 400;   // long receiver hold-off to back up the request side
   localparam int MAX_REPORTS = 20;

   // pacing of the two channels, carried by every request beat
   typedef enum logic [2:0] {
      PACE_FREE,        // no gaps on either side
      PACE_SEND_GAPS,   // sender holds back a beat with a 54 percent chance
      PACE_RSP_STALL,   // receiver drops ready with a 54 percent chance
      PACE_BOTH,        // both sides hold back with a 33 percent chance
      PACE_HOLDOFF      // receiver holds off for a long stretch once
   } pace_type;

   typedef struct {
      logic        op;
      logic [7:0]  task_id;
      logic        present;
      logic        init_ok;
      logic [31:0] period;
      logic [31:0] now_us;
      pace_type    pace;
   } beat_type;

   typedef struct {
      logic [1:0] kind;
      logic       reg_error;
      logic [7:0] due_task_id;
      logic [3:0] due_slot;
      logic       last;
   } outcome_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [0:0]  req_tuser  = '0;   // op
   logic [79:0] req_tdata  = '0;   // task_id, task_present, init_ok, period, now_us, zero fill
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [1:0]  rsp_tuser;         // kind
   logic [15:0] rsp_tdata;         // reg_error, due_task_id, due_slot, zero fill
   logic        rsp_tlast;         // last

   periodic_task_dispatcher_unit #(
      .MAX_TASKS(MAX_SLOTS),
      .TIME_BITS(32)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // scheduler mirror: one table, updated in the order beats are taken
   logic [7:0]  slot_task     [MAX_SLOTS];
   logic [31:0] slot_period   [MAX_SLOTS];
   logic [31:0] slot_last_run [MAX_SLOTS];
   int          slots_used = 0;

   beat_type    pending_beats[$];    // request beats not yet put on the bus
   outcome_type dispatch_out[$];     // results the block still owes, oldest first
   beat_type    live_beat;           // beat currently offered on req
   beat_type    next_beat;
   pace_type    cur_pace = PACE_FREE;

   int beats_total = 0;
   int beats_taken = 0;
   int failures    = 0;
   int hold_left   = 0;
   logic hold_done = 1'b0;

   // coverage tallies for the closing summary
   int reg_beats  = 0;
   int reg_ok     = 0;
   int tick_beats = 0;
   int due_count  = 0;
   int idle_ticks = 0;
   int most_due   = 0;

   logic [31:0] sim_now = '0;     // running clock used to build tick beats
   logic [7:0]  used_ids[$];      // ids offered for registration, reused to force duplicates

   // ------------------------------------------------------------------
   // scheduler: works out the results of one accepted beat
   // ------------------------------------------------------------------
   task automatic run_scheduler(input beat_type b);
      outcome_type o;
      logic        dup;
      logic [31:0] gap;
      int          n;
      o = '{kind: ptd_pkg::KIND_STATUS, reg_error: 1'b1, due_task_id: 8'd0, due_slot: 4'd0,
            last: 1'b1};
      if (b.op == ptd_pkg::OP_REGISTER) begin
         reg_beats++;
         dup = 1'b0;
         for (int i = 0; i < slots_used; i++) begin
            if (slot_task[i] == b.task_id) dup = 1'b1;
         end
         // null task, failed init, duplicate id or full table all report an error
         if (b.present && b.init_ok && !dup && slots_used < MAX_SLOTS) begin
            slot_task[slots_used]     = b.task_id;
            slot_period[slots_used]   = b.period;
            slot_last_run[slots_used] = '0;
            slots_used++;
            o.reg_error = 1'b0;
            reg_ok++;
         end
         dispatch_out.push_back(o);
      end else begin
         tick_beats++;
         n = 0;
         // one time value for the whole walk, elapsed time wraps at 32 bits
         for (int i = 0; i < slots_used; i++) begin
            gap = b.now_us - slot_last_run[i];
            if (gap >= slot_period[i]) begin
               slot_last_run[i] = b.now_us;
               o = '{kind: ptd_pkg::KIND_DUE, reg_error: 1'b0, due_task_id: slot_task[i],
                     due_slot: 4'(i), last: 1'b0};
               dispatch_out.push_back(o);
               n++;
            end
         end
         if (n == 0) begin
            o = '{kind: ptd_pkg::KIND_NONE, reg_error: 1'b0, due_task_id: 8'd0,
                  due_slot: 4'd0, last: 1'b1};
            dispatch_out.push_back(o);
            idle_ticks++;
         end else begin
            dispatch_out[dispatch_out.size() - 1].last = 1'b1;
            due_count += n;
            if (n > most_due) most_due = n;
         end
      end
   endtask

   // ------------------------------------------------------------------
   // stimulus builders
   // ------------------------------------------------------------------
   task automatic add_reg(input logic [7:0] id, input logic present, input logic init_ok,
                          input logic [31:0] period, input pace_type p);
      beat_type b;
      b = '{op: ptd_pkg::OP_REGISTER, task_id: id, present: present, init_ok: init_ok,
            period: period, now_us: $urandom, pace: p};
      used_ids.push_back(id);
      pending_beats.push_back(b);
   endtask

   task automatic add_tick(input logic [31:0] now_us, input pace_type p);
      beat_type b;
      // register-only fields carry noise on a tick
      b = '{op: ptd_pkg::OP_TICK, task_id: 8'($urandom), present: 1'($urandom),
            init_ok: 1'($urandom), period: $urandom, now_us: now_us, pace: p};
      pending_beats.push_back(b);
   endtask

   task automatic add_random(input pace_type p);
      logic [7:0]  id;
      logic [31:0] period;
      int          pick;
      if ($urandom_range(99) < 28) begin
         id = 8'($urandom);
         if (used_ids.size() != 0 && $urandom_range(3) == 0)
            id = used_ids[$urandom_range(used_ids.size() - 1)];
         pick = $urandom_range(99);
         if (pick < 40)      period = $urandom_range(600);
         else if (pick < 55) period = '0;
         else if (pick < 65) period = '1;
         else                period = $urandom;
         add_reg(id, $urandom_range(9) != 0, $urandom_range(9) != 0, period, p);
      end else begin
         pick = $urandom_range(99);
         if (pick < 70)      sim_now = sim_now + 32'($urandom_range(400));
         else if (pick < 85) sim_now = $urandom;
         else                sim_now = 32'hFFFF_FF00 + 32'($urandom_range(255));
         add_tick(sim_now, p);
      end
   endtask

   // ------------------------------------------------------------------
   // clock and reset
   // ------------------------------------------------------------------
   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
   end

   // ------------------------------------------------------------------
   // request driver: pops the pending beats, predicts at acceptance
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            run_scheduler(live_beat);
            beats_taken++;
         end
         // a new beat may go out once the current one is gone or none is offered
         if (!req_tvalid || req_tready) begin
            if (pending_beats.size() != 0 &&
                !((pending_beats[0].pace == PACE_SEND_GAPS && $urandom_range(99) < 54) ||
                  (pending_beats[0].pace == PACE_BOTH && $urandom_range(99) < 33))) begin
               next_beat = pending_beats.pop_front();
               live_beat  <= next_beat;
               cur_pace   <= next_beat.pace;
               req_tvalid <= 1'b1;
               req_tuser  <= next_beat.op;
               req_tdata  <= {6'd0, next_beat.now_us, next_beat.period, next_beat.init_ok,
                              next_beat.present, next_beat.task_id};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // long receiver hold-off, started once the hold-off phase reaches the bus
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (!hold_done && cur_pace == PACE_HOLDOFF) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // ------------------------------------------------------------------
   // result monitor: checks every result beat against the oldest prediction
   // ------------------------------------------------------------------
   task automatic check_result();
      outcome_type want;
      if (dispatch_out.size() == 0) begin
         failures++;
         if (failures <= MAX_REPORTS)
            $display("%0t: unexpected result beat kind=%0d err=%0b id=%0d slot=%0d last=%0b",
                     $time, rsp_tuser, rsp_tdata[0], rsp_tdata[8:1], rsp_tdata[12:9],
                     rsp_tlast);
      end else begin
         want = dispatch_out.pop_front();
         if (rsp_tuser !== want.kind || rsp_tdata[0] !== want.reg_error ||
             rsp_tdata[8:1] !== want.due_task_id || rsp_tdata[12:9] !== want.due_slot ||
             rsp_tlast !== want.last) begin
            failures++;
            if (failures <= MAX_REPORTS)
               $display("%0t: mismatch expected kind=%0d err=%0b id=%0d slot=%0d last=%0b, %s",
                        $time, want.kind, want.reg_error, want.due_task_id, want.due_slot,
                        want.last,
                        $sformatf("actual kind=%0d err=%0b id=%0d slot=%0d last=%0b",
                                  rsp_tuser, rsp_tdata[0], rsp_tdata[8:1], rsp_tdata[12:9],
                                  rsp_tlast));
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_result();
         rsp_tready <= (hold_left == 0) &&
                       !((cur_pace == PACE_RSP_STALL && $urandom_range(99) < 54) ||
                         (cur_pace == PACE_BOTH && $urandom_range(99) < 33));
      end
   end

   // ------------------------------------------------------------------
   // stimulus and end of run
   // ------------------------------------------------------------------
   initial begin
      // directed: empty table, rejected registrations, period and time extremes
      add_tick(32'd0, PACE_FREE);                        // nothing listed yet
      add_reg(8'd5, 1'b0, 1'b1, 32'd10, PACE_FREE);      // null task
      add_reg(8'd5, 1'b1, 1'b0, 32'd10, PACE_FREE);      // init failed
      add_reg(8'd0, 1'b1, 1'b1, 32'd0, PACE_FREE);       // lowest id, zero period
      add_reg(8'd0, 1'b1, 1'b1, 32'd7, PACE_FREE);       // duplicate id
      add_reg(8'd255, 1'b1, 1'b1, 32'hFFFF_FFFF, PACE_FREE);
      add_reg(8'h5A, 1'b1, 1'b1, 32'd100, PACE_FREE);
      add_tick(32'd0, PACE_FREE);                        // only the zero period is due
      add_tick(32'd99, PACE_FREE);                       // one short of the period
      add_tick(32'd100, PACE_FREE);                      // exactly at the period
      add_tick(32'hFFFF_FFFF, PACE_FREE);                // all three due, largest period too
      add_tick(32'h0000_0010, PACE_FREE);                // elapsed time wraps past zero
      add_tick(32'h0000_0063, PACE_FREE);                // wrapped elapsed equals the period
      add_reg(8'hA5, 1'b1, 1'b1, 32'h8000_0000, PACE_FREE);
      add_tick(32'h8000_0000, PACE_FREE);

      // random: phases with different pacing
      sim_now = 32'h8000_0000;
      repeat (60) add_random(PACE_FREE);
      repeat (90) add_random(PACE_SEND_GAPS);
      repeat (90) add_random(PACE_RSP_STALL);
      repeat (90) add_random(PACE_BOTH);
      repeat (30) add_random(PACE_HOLDOFF);
      repeat (60) add_random(PACE_FREE);
      beats_total = pending_beats.size();

      @(negedge reset);
      while (beats_taken < beats_total || dispatch_out.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d registrations (%0d listed, table holds %0d) and %0d ticks",
               reg_beats, reg_ok, slots_used, tick_beats);
      $display("ticks dispatched %0d tasks, up to %0d in one walk, %0d ticks found none due",
               due_count, most_due, idle_ticks);
      if (failures == 0 && dispatch_out.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // watchdog: far beyond the slowest correct run
   initial begin
      #4_000_000;
      $display("timeout with %0d of %0d beats taken, %0d results outstanding",
               beats_taken, beats_total, dispatch_out.size());
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
